>>> hw/rtl/ffua_pkg.sv
// Shared types and constants of the first-fit unit allocator.
// Used by the cell chain, the top level and the port checker; depends on nothing.
package ffua_pkg;

    // Free-map units held by one cell of the chain.
    localparam int unsigned CELL_UNITS = 16;
    localparam int unsigned POS_W      = $clog2(CELL_UNITS);

    // Field widths fixed by the request and result words.
    localparam int unsigned CNT_W = 11;
    localparam int unsigned GNT_W = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [CNT_W-1:0] start_offset;
        logic [CNT_W-1:0] unit_count;
    } t_in;

    typedef struct packed {
        logic             status;
        logic [GNT_W-1:0] granted_offset;
        logic [CNT_W-1:0] freed_count;
    } t_out;

    // Token control that travels from cell to cell.
    typedef struct packed {
        logic vld;       // token present
        logic mark;      // 1: write a range, 0: search for a run
        logic set_free;  // value written by a mark token
        logic found;     // search token already holds a fitting run
    } t_ctl;

endpackage

>>> hw/rtl/ffua_cell.sv
// One cell of the allocator chain: holds CELL_UNITS free-map bits.
// Searches for a fitting run or writes a range as a token passes; uses ffua_pkg.
module ffua_cell
    import ffua_pkg::*;
#(
    parameter int unsigned NUM_UNITS = 1024,
    parameter int unsigned CELL_IDX  = 0,
    parameter int unsigned PW        = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic [CNT_W-1:0] i_run,
    input  logic [CNT_W-1:0] i_count,
    input  logic [PW-1:0]    i_lo,
    input  logic [PW-1:0]    i_hi,
    output t_ctl             o_ctl,
    output logic [CNT_W-1:0] o_run,
    output logic [CNT_W-1:0] o_count,
    output logic [PW-1:0]    o_lo,
    output logic [PW-1:0]    o_hi
);

    localparam int unsigned BASE = CELL_IDX * CELL_UNITS;
    localparam int unsigned CW   = (PW > CNT_W + 1) ? PW : CNT_W + 1;

    logic [CELL_UNITS-1:0] r_free;
    t_ctl                  r_ctl;
    logic [CNT_W-1:0]      r_run;
    logic [CNT_W-1:0]      r_count;
    logic [PW-1:0]         r_lo;
    logic [PW-1:0]         r_hi;

    t_ctl                  n_ctl;
    logic [CNT_W-1:0]      n_run;
    logic [PW-1:0]         n_lo;
    logic [PW-1:0]         n_hi;

    logic [CELL_UNITS-1:0] win [CELL_UNITS];
    logic [CELL_UNITS-1:0] fit;
    logic [CELL_UNITS-1:0] first;
    logic [CELL_UNITS-1:0] tail;
    logic [CELL_UNITS-1:0] in_rng;
    logic [POS_W-1:0]      pos;
    logic [CW-1:0]         end_idx;
    logic [CNT_W:0]        run_sum;
    logic                  hit;
    logic                  searching;

    // A run ending at unit j fits when every unit of the window inside this cell
    // is free and the run carried in from lower cells covers the rest.
    always_comb begin
        for (int j = 0; j < CELL_UNITS; j++) begin
            for (int i = 0; i < CELL_UNITS; i++) begin
                if (i <= j) begin
                    win[j][i] = (CNT_W'(j - i) < i_count);
                end else begin
                    win[j][i] = 1'b0;
                end
            end
            fit[j] = ~|(win[j] & ~r_free) &&
                     ((i_count <= CNT_W'(j + 1)) ||
                      (({1'b0, i_run} + (CNT_W + 1)'(j + 1)) >= {1'b0, i_count}));
        end
        first = fit & (~fit + 1'b1);
        hit   = |fit;
        pos   = '0;
        for (int j = 0; j < CELL_UNITS; j++) begin
            if (first[j]) begin
                pos = pos | POS_W'(j);
            end
        end
        end_idx = CW'(BASE) + CW'(pos);

        // Free units at the top end of the cell start the run handed on.
        for (int i = 0; i < CELL_UNITS; i++) begin
            tail[i] = &(r_free | CELL_UNITS'((1 << i) - 1));
        end

        for (int i = 0; i < CELL_UNITS; i++) begin
            in_rng[i] = (PW'(BASE + i) >= i_lo) && (PW'(BASE + i) < i_hi);
        end
    end

    assign searching = i_ctl.vld && !i_ctl.mark && !i_ctl.found;

    always_comb begin
        n_ctl   = i_ctl;
        n_lo    = i_lo;
        n_hi    = i_hi;
        run_sum = {1'b0, i_run} + (CNT_W + 1)'(CELL_UNITS);
        if (&r_free) begin
            // Hold the carried run at its ceiling; it already covers any count.
            n_run = run_sum[CNT_W] ? '1 : run_sum[CNT_W-1:0];
        end else begin
            n_run = CNT_W'($countones(tail));
        end
        if (searching && hit) begin
            n_ctl.found = 1'b1;
            n_lo        = PW'(end_idx + CW'(1) - CW'(i_count));
            n_hi        = PW'(end_idx + CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            for (int i = 0; i < CELL_UNITS; i++) begin
                r_free[i] <= (BASE + i < NUM_UNITS);
            end
        end else begin
            r_ctl <= n_ctl;
            if (i_ctl.vld && i_ctl.mark) begin
                for (int i = 0; i < CELL_UNITS; i++) begin
                    if (in_rng[i]) begin
                        r_free[i] <= i_ctl.set_free;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run   <= n_run;
        r_count <= i_count;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
    end

    assign o_ctl   = r_ctl;
    assign o_run   = r_run;
    assign o_count = r_count;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;

endmodule

>>> hw/rtl/first_fit_unit_allocator.sv
// First-fit unit allocator: top level with the request sequencer and the cell chain.
// Uses ffua_pkg and ffua_cell.
//
// The block keeps one free bit per unit in a chain of cells of 16 units each,
// NUM_UNITS/16 cells rounded up, and takes one request word at a time while busy
// is low. An allocate sends a search token down the chain, one cell a cycle, then
// a marking token down again, so its result appears once the marking token has
// left the last cell; an allocate that finds no run answers once the search
// token has left the last cell. A free sends one marking token and answers once
// that token has left the last cell. A zero count or a free outside the store
// answers in the next cycle. Each result word is shown for one cycle with
// o_done high and must be taken then; the receiver cannot stall the block.
module first_fit_unit_allocator
    import ffua_pkg::*;
#(
    parameter int unsigned NUM_UNITS = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_req,
    output logic o_done,
    output t_out o_res
);

    localparam int unsigned NUM_CELLS = (NUM_UNITS + CELL_UNITS - 1) / CELL_UNITS;
    localparam int unsigned PAD_UNITS = NUM_CELLS * CELL_UNITS;
    localparam int unsigned PW        = $clog2(PAD_UNITS) + 1;
    localparam int unsigned CW        = (PW > CNT_W + 1) ? PW : CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_MARK = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_ctl             r_inj, n_inj;
    logic             r_op, n_op;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PW-1:0]    r_lo, n_lo;
    logic [PW-1:0]    r_hi, n_hi;
    logic [GNT_W-1:0] r_gnt, n_gnt;
    logic             r_done, n_done;
    t_out             r_res, n_res;

    t_ctl             w_ctl   [NUM_CELLS+1];
    logic [CNT_W-1:0] w_run   [NUM_CELLS+1];
    logic [CNT_W-1:0] w_count [NUM_CELLS+1];
    logic [PW-1:0]    w_lo    [NUM_CELLS+1];
    logic [PW-1:0]    w_hi    [NUM_CELLS+1];

    logic [CW-1:0]    free_end;
    logic             free_ok;

    assign w_ctl[0]   = r_inj;
    assign w_run[0]   = '0;
    assign w_count[0] = r_count;
    assign w_lo[0]    = r_lo;
    assign w_hi[0]    = r_hi;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        ffua_cell #(
            .NUM_UNITS (NUM_UNITS),
            .CELL_IDX  (k),
            .PW        (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .i_run   (w_run[k]),
            .i_count (w_count[k]),
            .i_lo    (w_lo[k]),
            .i_hi    (w_hi[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_run   (w_run[k+1]),
            .o_count (w_count[k+1]),
            .o_lo    (w_lo[k+1]),
            .o_hi    (w_hi[k+1])
        );
    end

    assign free_end = CW'(i_req.start_offset) + CW'(i_req.unit_count);
    assign free_ok  = (i_req.unit_count != '0) && (free_end <= CW'(NUM_UNITS));
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_inj   = '0;
        n_op    = r_op;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_gnt   = r_gnt;
        n_done  = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_req.opcode;
                    n_count = i_req.unit_count;
                    n_gnt   = '0;
                    if (i_req.opcode == OP_ALLOC) begin
                        if (i_req.unit_count == '0) begin
                            n_done = 1'b1;
                            n_res  = '{status: ST_FAIL, default: '0};
                        end else begin
                            n_inj.vld = 1'b1;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (free_ok) begin
                            n_inj.vld      = 1'b1;
                            n_inj.mark     = 1'b1;
                            n_inj.set_free = 1'b1;
                            n_lo           = PW'(i_req.start_offset);
                            n_hi           = PW'(free_end);
                            n_state        = S_MARK;
                        end else begin
                            n_done = 1'b1;
                            n_res  = '{status: ST_FAIL, default: '0};
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_ctl[NUM_CELLS].vld) begin
                    if (w_ctl[NUM_CELLS].found) begin
                        // Claim the run found: send a marking token from cell 0.
                        n_inj.vld  = 1'b1;
                        n_inj.mark = 1'b1;
                        n_lo       = w_lo[NUM_CELLS];
                        n_hi       = w_hi[NUM_CELLS];
                        n_gnt      = GNT_W'(w_lo[NUM_CELLS]);
                        n_state    = S_MARK;
                    end else begin
                        n_done  = 1'b1;
                        n_res   = '{status: ST_FAIL, default: '0};
                        n_state = S_IDLE;
                    end
                end
            end
            S_MARK: begin
                if (w_ctl[NUM_CELLS].vld) begin
                    n_done               = 1'b1;
                    n_res.status         = ST_OK;
                    n_res.granted_offset = (r_op == OP_ALLOC) ? r_gnt : '0;
                    n_res.freed_count    = (r_op == OP_FREE) ? r_count : '0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inj   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj   <= n_inj;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_count <= n_count;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_gnt   <= n_gnt;
        r_res   <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> hw/rtl/ffua_checker.sv
// Port-level checks of the first-fit unit allocator, bound to the top level.
// Uses ffua_pkg; sees only the top-level ports.
module ffua_checker
    import ffua_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_req,
    input logic o_done,
    input t_out o_res
);

    // A result word is only given once the request has finished.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word while busy");

    // Busy only rises after an accepted request word.
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_FAIL) |->
            (o_res.granted_offset == '0 && o_res.freed_count == '0))
        else $error("failed result carries data");

    // A successful free never reports a granted offset.
    a_free_gnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_OK && o_res.freed_count != '0) |->
            o_res.granted_offset == '0)
        else $error("free result carries a granted offset");

    // A zero-count request word, allocate or free, never starts work.
    a_zero_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.unit_count == '0) |=> !busy)
        else $error("zero-count request started work");

endmodule

bind first_fit_unit_allocator ffua_checker u_ffua_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_res   (o_res)
);
